>>> hdl/dpre_pkg.sv
`default_nettype none
package dpre_pkg;

   // Field widths fixed by the word formats.
   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_CHANNELS   = 8;
   localparam int SUM_BITS       = 53;
   localparam int FPP_BITS       = 20;
   localparam int CH_REG_BITS    = 4;
   localparam int INDEX_BITS     = 32;
   localparam int OUT_BITS       = 16;
   localparam int ROOT_BITS      = 15;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [FPP_BITS-1:0]    FPP_RESET = 20'd480;
   localparam logic [CH_REG_BITS-1:0] CH_RESET  = 4'd2;
   localparam logic [OUT_BITS-1:0]    RMS_LIMIT = 16'h8000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_PER_POINT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT    = 4'd1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          frame_end;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0]   peak;
      logic [OUT_BITS-1:0]   rms;
      logic [INDEX_BITS-1:0] point_index;
   } rsp_type;

   // One finished point waiting for its divide and root.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] peak;
      logic [SUM_BITS-1:0]    sum;
      logic [FPP_BITS-1:0]    frames;
      logic [CH_REG_BITS-1:0] channels;
      logic [INDEX_BITS-1:0]  index;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hdl/dpre_front.sv
`default_nettype none
module dpre_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  dpre_pkg::req_type                req_data,
   input  wire [dpre_pkg::FPP_BITS-1:0]     frames_per_point,
   input  wire [dpre_pkg::CH_REG_BITS-1:0]  channel_count,
   input  dpre_pkg::queue_status_type       q_status,
   output logic                             push,
   output dpre_pkg::job_type                job
);

   localparam int S = dpre_pkg::SAMPLE_BITS;

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_cmd_ff;
   logic                            s1_end_ff;
   logic [S-1:0]                    s1_mag_ff;
   logic [2*S-1:0]                  s1_sq_ff;

   logic [S-1:0]                    peak_ff, peak_in;
   logic [dpre_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   logic [dpre_pkg::FPP_BITS-1:0]   frames_ff, frames_in;
   logic [dpre_pkg::INDEX_BITS-1:0] index_ff, index_in;

   logic [S-1:0]                    raw;
   logic [S-1:0]                    mag;
   logic [2*S-1:0]                  sq;
   logic                            accept;
   logic [S-1:0]                    peak_new;
   logic [dpre_pkg::SUM_BITS:0]     sum_wide;
   logic [dpre_pkg::SUM_BITS-1:0]   sum_new;
   logic [dpre_pkg::FPP_BITS-1:0]   frames_next;
   logic [dpre_pkg::FPP_BITS-1:0]   fpp_eff;
   logic                            emit;
   logic                            s2_go;

   // The negation of the most negative sample lands on its exact magnitude as unsigned.
   assign raw = req_data.sample;
   assign mag = raw[S-1] ? ((~raw) + {{(S-1){1'b0}}, 1'b1}) : raw;
   assign sq  = {{S{1'b0}}, mag} * {{S{1'b0}}, mag};

   assign peak_new    = (s1_mag_ff > peak_ff) ? s1_mag_ff : peak_ff;
   assign sum_wide    = {1'b0, sum_ff} + {{(dpre_pkg::SUM_BITS + 1 - 2*S){1'b0}}, s1_sq_ff};
   assign sum_new     = sum_wide[dpre_pkg::SUM_BITS] ? '1 : sum_wide[dpre_pkg::SUM_BITS-1:0];
   assign frames_next = frames_ff + {{(dpre_pkg::FPP_BITS-1){1'b0}}, 1'b1};
   assign fpp_eff     = (frames_per_point == '0) ?
                        {{(dpre_pkg::FPP_BITS-1){1'b0}}, 1'b1} : frames_per_point;

   assign emit  = s1_valid_ff && (s1_cmd_ff == dpre_pkg::CMD_SAMPLE) && s1_end_ff &&
                  (frames_next >= fpp_eff);
   assign s2_go = s1_valid_ff && !(emit && q_status.full);
   assign push  = emit && !q_status.full;

   assign req_stall = s1_valid_ff && !s2_go;
   assign accept    = req_valid && !req_stall;

   assign job.peak     = peak_new;
   assign job.sum      = sum_new;
   assign job.frames   = frames_next;
   assign job.channels = channel_count;
   assign job.index    = index_ff;

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_valid_ff && !s2_go);
      peak_in     = peak_ff;
      sum_in      = sum_ff;
      frames_in   = frames_ff;
      index_in    = index_ff;
      if (s2_go) begin
         if (s1_cmd_ff == dpre_pkg::CMD_CLEAR) begin
            peak_in   = '0;
            sum_in    = '0;
            frames_in = '0;
            index_in  = '0;
         end else if (emit) begin
            peak_in   = '0;
            sum_in    = '0;
            frames_in = '0;
            index_in  = index_ff + {{(dpre_pkg::INDEX_BITS-1){1'b0}}, 1'b1};
         end else begin
            peak_in = peak_new;
            sum_in  = sum_new;
            if (s1_end_ff) begin
               frames_in = frames_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         peak_ff     <= '0;
         sum_ff      <= '0;
         frames_ff   <= '0;
         index_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         peak_ff     <= peak_in;
         sum_ff      <= sum_in;
         frames_ff   <= frames_in;
         index_ff    <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req_data.cmd;
         s1_end_ff <= req_data.frame_end;
         s1_mag_ff <= mag;
         s1_sq_ff  <= sq;
      end
   end

endmodule
`default_nettype wire

>>> hdl/dpre_queue.sv
`default_nettype none
module dpre_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  dpre_pkg::job_type           job_in,
   input  wire                         pop,
   output dpre_pkg::job_type           job_out,
   output dpre_pkg::queue_status_type  status
);

   localparam int DEPTH      = dpre_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   dpre_pkg::job_type       entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == COUNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign job_out      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end else if (pop && !push) begin
         count_in = count_ff - {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/dpre_back.sv
`default_nettype none
module dpre_back #(
   parameter int MAX_CHANNELS = dpre_pkg::MAX_CHANNELS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  dpre_pkg::job_type           job,
   input  dpre_pkg::queue_status_type  q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output dpre_pkg::rsp_type           rsp_data
);

   localparam int CH_BITS   = (MAX_CHANNELS >= 15) ? dpre_pkg::CH_REG_BITS :
                              $clog2(MAX_CHANNELS + 1);
   localparam int DEN_BITS  = dpre_pkg::FPP_BITS + CH_BITS;
   localparam int SUM_BITS  = dpre_pkg::SUM_BITS;
   localparam int RB        = dpre_pkg::ROOT_BITS;
   localparam int RREM_BITS = RB + 2;
   localparam int CNT_BITS  = $clog2(SUM_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROOT,
      ST_FIN
   } state_type;

   state_type                       state_ff;
   logic [CNT_BITS-1:0]             cnt_ff;
   logic [DEN_BITS-1:0]             den_ff;
   logic                            den_zero_ff;
   logic [DEN_BITS-1:0]             rem_ff;
   logic [SUM_BITS-1:0]             quo_ff;
   logic [RB-1:0]                   root_ff;
   logic [RREM_BITS-1:0]            rrem_ff;
   logic [dpre_pkg::OUT_BITS-1:0]   peak_ff;
   logic [dpre_pkg::INDEX_BITS-1:0] index_ff;
   logic                            rsp_valid_ff;
   dpre_pkg::rsp_type               rsp_ff;

   logic [CH_BITS-1:0]              ch_clamped;
   logic [DEN_BITS-1:0]             den;
   logic [DEN_BITS:0]               rem_shift;
   logic                            div_ge;
   logic [DEN_BITS-1:0]             rem_in;
   logic [SUM_BITS-1:0]             quo_div_in;
   logic [RREM_BITS+1:0]            rrem_shift;
   logic [RREM_BITS+1:0]            trial;
   logic                            root_ge;
   logic [RREM_BITS-1:0]            rrem_in;
   logic [RB-1:0]                   root_in;
   logic [SUM_BITS-1:0]             quo_root_in;
   logic                            quo_high;
   logic [dpre_pkg::OUT_BITS-1:0]   rms_value;

   assign ch_clamped = (int'(job.channels) > MAX_CHANNELS) ? CH_BITS'(MAX_CHANNELS) :
                       job.channels[CH_BITS-1:0];
   assign den        = DEN_BITS'(job.frames) * DEN_BITS'(ch_clamped);

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   // Restoring division, one quotient bit per cycle, shifted in behind the dividend.
   assign rem_shift  = {rem_ff, quo_ff[SUM_BITS-1]};
   assign div_ge     = (rem_shift >= {1'b0, den_ff});
   assign rem_in     = div_ge ? DEN_BITS'(rem_shift - {1'b0, den_ff}) :
                       rem_shift[DEN_BITS-1:0];
   assign quo_div_in = {quo_ff[SUM_BITS-2:0], div_ge};

   // Digit-by-digit root over the low bits of the quotient, two bits per cycle.
   assign rrem_shift  = {rrem_ff, quo_ff[2*RB-1 -: 2]};
   assign trial       = {2'b00, root_ff, 2'b01};
   assign root_ge     = (rrem_shift >= trial);
   assign rrem_in     = root_ge ? RREM_BITS'(rrem_shift - trial) : RREM_BITS'(rrem_shift);
   assign root_in     = {root_ff[RB-2:0], root_ge};
   assign quo_root_in = {quo_ff[SUM_BITS-1:2*RB], quo_ff[2*RB-3:0], 2'b00};

   // A quotient at or above the square of the limit saturates the root.
   assign quo_high  = (quo_ff[SUM_BITS-1:2*RB] != '0);
   assign rms_value = den_zero_ff ? '0 :
                      quo_high ? dpre_pkg::RMS_LIMIT : dpre_pkg::OUT_BITS'(root_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  den_ff      <= den;
                  den_zero_ff <= (den == '0);
                  rem_ff      <= '0;
                  quo_ff      <= job.sum;
                  peak_ff     <= dpre_pkg::OUT_BITS'(job.peak);
                  index_ff    <= job.index;
                  cnt_ff      <= CNT_BITS'(SUM_BITS - 1);
                  state_ff    <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= quo_div_in;
               if (cnt_ff == '0) begin
                  cnt_ff   <= CNT_BITS'(RB - 1);
                  root_ff  <= '0;
                  rrem_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  cnt_ff <= cnt_ff - {{(CNT_BITS-1){1'b0}}, 1'b1};
               end
            end
            ST_ROOT: begin
               root_ff <= root_in;
               rrem_ff <= rrem_in;
               quo_ff  <= quo_root_in;
               if (cnt_ff == '0) begin
                  state_ff <= ST_FIN;
               end else begin
                  cnt_ff <= cnt_ff - {{(CNT_BITS-1){1'b0}}, 1'b1};
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.peak        <= peak_ff;
                  rsp_ff.rms         <= rms_value;
                  rsp_ff.point_index <= index_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> hdl/decimating_peak_rms_envelope.sv
// Peak and RMS envelope decimator for interleaved audio.
//
// The request channel (req_valid, req_stall, req_data) carries one word per
// channel sample, Q1.15, with frame_end set on the last channel of a frame.
// A word with cmd set to clear restarts the accumulators and the point count.
// Sample words are taken at one per cycle unless the front stage stalls; it
// squares each sample into its stage register and accumulates it from there.
// Once frames_per_point frames have closed, the finished point is queued and
// a shared serial unit divides the sum of squares by frames times channels
// (one quotient bit per cycle) and then takes the square root (two bits per
// cycle). The back end works on one point at a time; the two-entry queue
// holds further points meanwhile. While the receiver stalls, the finished
// word holds on rsp_data and the back end may compute the next point; input
// words stall only when the queue is full and another point closes. Reset is
// synchronous and clears the accumulators, the queue and the output; the
// registers return to 480 frames per point and two channels. Registers are
// to be written through csr_* only while idle; the block itself does not
// enforce this.
`default_nettype none
module decimating_peak_rms_envelope #(
   parameter int MAX_CHANNELS = dpre_pkg::MAX_CHANNELS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  dpre_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output dpre_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_wr_en,
   input  wire [dpre_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire [dpre_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [dpre_pkg::FPP_BITS-1:0]    fpp_ff;
   logic [dpre_pkg::CH_REG_BITS-1:0] ch_ff;

   logic                             q_push;
   logic                             q_pop;
   dpre_pkg::job_type                q_job_in;
   dpre_pkg::job_type                q_job_out;
   dpre_pkg::queue_status_type       q_status;

   // Writes to an index outside the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fpp_ff <= dpre_pkg::FPP_RESET;
         ch_ff  <= dpre_pkg::CH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dpre_pkg::CSR_FRAMES_PER_POINT: begin
               fpp_ff <= csr_wdata[dpre_pkg::FPP_BITS-1:0];
            end
            dpre_pkg::CSR_CHANNEL_COUNT: begin
               ch_ff <= csr_wdata[dpre_pkg::CH_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end squares and accumulates; it closes points into the queue.
   dpre_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .frames_per_point (fpp_ff),
      .channel_count    (ch_ff),
      .q_status         (q_status),
      .push             (q_push),
      .job              (q_job_in)
   );

   dpre_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (q_job_in),
      .pop     (q_pop),
      .job_out (q_job_out),
      .status  (q_status)
   );

   // The back end turns each queued point into a result word.
   dpre_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (q_job_out),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The front end must never close a point into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(q_push && q_status.full))
      else $error("point pushed into a full queue");

   // The back end must never take a point from an empty queue.
   assert property (@(posedge clock) disable iff (reset) !(q_pop && q_status.empty))
      else $error("point popped from an empty queue");

   // The root saturates at the limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rms <= dpre_pkg::RMS_LIMIT))
      else $error("rms above its limit");

   // Nothing is offered in the cycle after a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule
`default_nettype wire

>>> test/tb_decimating_peak_rms_envelope.sv
`default_nettype none
module tb_decimating_peak_rms_envelope;
   timeunit 1ns;
   timeprecision 1ps;

   import dpre_pkg::*;

   // Cycles to wait once the last expected point has arrived. The wait covers
   // a word that is still in the front stage as well as any point the block
   // should not have produced.
   localparam int DRAIN_CYCLES      = 100;
   localparam int RANDOM_SETTINGS   = 18;
   localparam int WORDS_PER_SETTING = 64;
   localparam int CSR_PAD_BITS      = CSR_DATA_BITS - CH_REG_BITS;
   localparam logic [63:0] SUM_FULL = (64'd1 << SUM_BITS) - 64'd1;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Idle rates in percent for the sending side and for the receiving side.
   int send_idle_pct = 34;
   int rsp_idle_pct  = 45;

   // Our own copy of the register file, as it stands after reset.
   logic [FPP_BITS-1:0]    frames_per_point_reg = FPP_RESET;
   logic [CH_REG_BITS-1:0] channel_count_reg    = CH_RESET;

   // Envelope state of the point that is being gathered.
   logic [SAMPLE_BITS-1:0] gather_peak       = '0;
   logic [SUM_BITS-1:0]    gather_energy     = '0;
   logic [FPP_BITS-1:0]    gather_frames     = '0;
   logic [INDEX_BITS-1:0]  next_point_index  = '0;

   // Points that the block still owes us, oldest first.
   rsp_type pending_points[$];

   int failures       = 0;
   int words_sent     = 0;
   int points_checked = 0;

   decimating_peak_rms_envelope dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor square root of the mean square, found one bit at a time from the
   // top. The mean square is below 2^53, so the root fits in 27 bits and a
   // trial square never leaves 64 bits. Anything above full scale is clipped.
   function automatic logic [OUT_BITS-1:0] rms_of(input logic [SUM_BITS-1:0] energy,
                                                  input logic [63:0] divisor);
      logic [63:0] mean_square;
      logic [63:0] root;
      logic [63:0] trial;
      if (divisor == 64'd0) return '0;
      mean_square = 64'(energy) / divisor;
      root = 64'd0;
      for (int b = 26; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= mean_square) root = trial;
      end
      if (root > 64'(RMS_LIMIT)) return RMS_LIMIT;
      return root[OUT_BITS-1:0];
   endfunction

   // Updates the envelope state with one accepted word and queues the point
   // that the word closes, if it closes one.
   task automatic accumulate_word(input req_type w);
      logic [SAMPLE_BITS:0]   magnitude;
      logic [63:0]            square;
      logic [FPP_BITS-1:0]    needed;
      logic [CH_REG_BITS-1:0] chans;
      rsp_type                point;
      if (w.cmd == CMD_CLEAR) begin
         // The sample and the frame flag of a clear word mean nothing.
         gather_peak      = '0;
         gather_energy    = '0;
         gather_frames    = '0;
         next_point_index = '0;
         return;
      end
      // The most negative sample keeps its full magnitude of 2^15.
      magnitude = w.sample[SAMPLE_BITS-1] ? -{1'b1, w.sample} : {1'b0, w.sample};
      if (magnitude > gather_peak) gather_peak = magnitude[SAMPLE_BITS-1:0];
      square = magnitude * magnitude;
      if (64'(gather_energy) > SUM_FULL - square) begin
         gather_energy = SUM_FULL[SUM_BITS-1:0];
      end else begin
         gather_energy = gather_energy + SUM_BITS'(square);
      end
      if (!w.frame_end) return;
      gather_frames = gather_frames + 1'b1;
      // A setting of zero frames behaves as one, and the test is "at least",
      // so lowering the register part way through a point closes it early.
      needed = (frames_per_point_reg == '0) ? FPP_BITS'(1) : frames_per_point_reg;
      if (gather_frames < needed) return;
      chans = (channel_count_reg > MAX_CHANNELS) ? CH_REG_BITS'(MAX_CHANNELS)
                                                 : channel_count_reg;
      point.peak        = gather_peak;
      point.rms         = rms_of(gather_energy, 64'(gather_frames) * 64'(chans));
      point.point_index = next_point_index;
      pending_points.insert(pending_points.size(), point);
      next_point_index = next_point_index + 1'b1;
      gather_peak      = '0;
      gather_energy    = '0;
      gather_frames    = '0;
   endtask

   // Offers one word on the request channel after a random number of idle
   // cycles, holds it steady while the block stalls, and returns at the
   // rising edge that takes it. The valid stays high for a word that follows
   // straight away.
   task automatic send_word(input logic cmd, input logic signed [SAMPLE_BITS-1:0] sample,
                            input logic frame_end);
      req_type w;
      w.cmd       = cmd;
      w.sample    = sample;
      w.frame_end = frame_end;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_word(w);
      words_sent++;
   endtask

   // Drops the request valid and waits until every expected point has come
   // out, then lets the pipeline empty before anything else is done.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; only the low bits that a register holds count, and
   // an index that names no register changes nothing.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_FRAMES_PER_POINT: frames_per_point_reg = value[FPP_BITS-1:0];
         CSR_CHANNEL_COUNT:    channel_count_reg    = value[CH_REG_BITS-1:0];
         default: ;
      endcase
   endtask

   // Mostly full-range noise, with full-scale values and quiet passages mixed in.
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(9))
         0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2:       return SAMPLE_BITS'($urandom_range(511) - 256);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // The registers come out of reset at 480 frames and two channels. One
   // point of single-sample frames shows both values at work.
   task automatic test_default_registers();
      for (int k = 0; k < FPP_RESET; k++) send_word(CMD_SAMPLE, random_sample(), 1'b1);
   endtask

   // Full-scale positive and negative samples, silence and the smallest
   // magnitudes. Three full-scale negative words in a single one-channel frame
   // push the root above full scale, so the rms field must clip.
   task automatic test_sample_extremes();
      settle();
      write_register(CSR_FRAMES_PER_POINT, CSR_DATA_BITS'(1));
      write_register(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(1));
      send_word(CMD_SAMPLE, 16'sh7FFF, 1'b1);
      send_word(CMD_SAMPLE, 16'sh8000, 1'b1);
      send_word(CMD_SAMPLE, 16'sh0000, 1'b1);
      send_word(CMD_SAMPLE, -16'sd1, 1'b1);
      send_word(CMD_SAMPLE, 16'sh5555, 1'b1);
      send_word(CMD_SAMPLE, 16'sh8000, 1'b0);
      send_word(CMD_SAMPLE, 16'sh8000, 1'b0);
      send_word(CMD_SAMPLE, 16'sh8000, 1'b1);
   endtask

   // A clear in the middle of a point throws the partial point away and
   // restarts the point count; its own sample and frame flag are ignored.
   task automatic test_clear_command();
      send_word(CMD_SAMPLE, 16'sd20000, 1'b0);
      send_word(CMD_CLEAR, 16'sh8000, 1'b1);
      send_word(CMD_SAMPLE, 16'sd3, 1'b1);
      send_word(CMD_CLEAR, 16'sh7FFF, 1'b0);
      send_word(CMD_SAMPLE, -16'sd40, 1'b1);
   endtask

   // Register corners: zero frames per point, zero channels (rms reads zero),
   // a channel count above the maximum (clamped), writes to indexes that name
   // no register, and the largest frame count lowered part way through a point.
   task automatic test_register_corners();
      settle();
      write_register(CSR_FRAMES_PER_POINT, '0);
      write_register(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(MAX_CHANNELS));
      send_word(CMD_SAMPLE, 16'sd12345, 1'b1);
      send_word(CMD_SAMPLE, -16'sd20000, 1'b1);
      settle();
      write_register(CSR_CHANNEL_COUNT, '0);
      send_word(CMD_SAMPLE, 16'sd30000, 1'b1);
      settle();
      write_register(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(15));
      write_register(CSR_INDEX_BITS'(2), CSR_DATA_BITS'(3));
      write_register({CSR_INDEX_BITS{1'b1}}, {CSR_DATA_BITS{1'b1}});
      send_word(CMD_SAMPLE, 16'sd1000, 1'b0);
      send_word(CMD_SAMPLE, -16'sd1000, 1'b0);
      send_word(CMD_SAMPLE, 16'sd7, 1'b1);
      settle();
      write_register(CSR_FRAMES_PER_POINT, {CSR_DATA_BITS{1'b1}});
      // The upper data bits are set as well; only the low four reach the register.
      write_register(CSR_CHANNEL_COUNT, {{CSR_PAD_BITS{1'b1}}, CH_REG_BITS'(1)});
      send_word(CMD_SAMPLE, 16'sh8000, 1'b1);
      send_word(CMD_SAMPLE, 16'sd5, 1'b1);
      send_word(CMD_SAMPLE, 16'sh7FFF, 1'b1);
      settle();
      write_register(CSR_FRAMES_PER_POINT, CSR_DATA_BITS'(2));
      send_word(CMD_SAMPLE, 16'sd9, 1'b1);
   endtask

   // Random register settings, each followed by a run of frames. Most frames
   // carry as many words as the channel count says; some are longer or shorter
   // and a few clear words are mixed in. The accumulators are not cleared
   // between settings, so a new setting often lands part way through a point.
   task automatic test_random_settings();
      int unsigned r;
      int unsigned fpp;
      int unsigned chans;
      int unsigned frame_len;
      int          start_words;
      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         case (s / (RANDOM_SETTINGS / 3))
            0: begin
               send_idle_pct = 34;
               rsp_idle_pct  = 45;
            end
            1: begin
               send_idle_pct = 45;
               rsp_idle_pct  = 34;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         r     = $urandom_range(99);
         fpp   = (r < 70) ? $urandom_range(1, 4) :
                 (r < 90) ? $urandom_range(5, 12) : $urandom_range(0, 40);
         chans = ($urandom_range(4) == 0) ? $urandom_range(0, 15)
                                          : $urandom_range(1, MAX_CHANNELS);
         // Make sure the extremes turn up whatever the seed.
         if (s == 0) begin
            fpp   = 1;
            chans = MAX_CHANNELS;
         end
         if (s == RANDOM_SETTINGS / 3) begin
            fpp   = 1;
            chans = 1;
         end
         settle();
         write_register(CSR_FRAMES_PER_POINT, CSR_DATA_BITS'(fpp));
         write_register(CSR_CHANNEL_COUNT, {CSR_PAD_BITS'($urandom), CH_REG_BITS'(chans)});
         start_words = words_sent;
         while (words_sent - start_words < WORDS_PER_SETTING) begin
            if ($urandom_range(99) < 3) begin
               send_word(CMD_CLEAR, random_sample(), 1'($urandom));
               continue;
            end
            frame_len = (chans == 0) ? 1 : (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
            if ($urandom_range(99) < 15) frame_len = $urandom_range(1, 10);
            for (int k = 1; k <= frame_len; k++) begin
               send_word(CMD_SAMPLE, random_sample(), k == frame_len);
            end
         end
      end
   endtask

   // The receiving side stalls at random; it is quiet during reset.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
   end

   // Every point that the block hands over is compared, field by field, with
   // the oldest point that the prediction still holds.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point: peak %0d rms %0d point_index %0d",
                   rsp_data.peak, rsp_data.rms, rsp_data.point_index);
            failures++;
         end else begin
            want = pending_points[0];
            pending_points.delete(0);
            if (rsp_data.peak !== want.peak) begin
               $error("peak: expected %0d, got %0d", want.peak, rsp_data.peak);
               failures++;
            end
            if (rsp_data.rms !== want.rms) begin
               $error("rms: expected %0d, got %0d", want.rms, rsp_data.rms);
               failures++;
            end
            if (rsp_data.point_index !== want.point_index) begin
               $error("point_index: expected %0d, got %0d",
                      want.point_index, rsp_data.point_index);
               failures++;
            end
            points_checked++;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_sample_extremes();
      test_clear_command();
      test_register_corners();
      test_random_settings();
      settle();
      if (pending_points.size() != 0) begin
         $error("%0d expected points never arrived", pending_points.size());
         failures++;
      end
      $display("Sent %0d input words and compared %0d envelope points.",
               words_sent, points_checked);
      $display("Covered reset values, full-scale samples, clears, register corners and %0d %s",
               RANDOM_SETTINGS, "random register settings under varying back-pressure.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Far beyond the slowest correct run, even with every word closing a point.
   initial begin
      #15_000_000;
      $display("Timed out waiting for the block.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
hdl/dpre_pkg.sv
hdl/dpre_front.sv
hdl/dpre_queue.sv
hdl/dpre_back.sv
hdl/decimating_peak_rms_envelope.sv
test/tb_decimating_peak_rms_envelope.sv
